@@ rtl/windowed_nearest_timestamp_match_assert.svh @@
// Assertion macros for the nearest timestamp matcher.
// Used by the datapath; no dependencies. Empty under SYNTHESIS.
`ifndef WINDOWED_NEAREST_TIMESTAMP_MATCH_ASSERT_SVH
`define WINDOWED_NEAREST_TIMESTAMP_MATCH_ASSERT_SVH

`ifndef SYNTHESIS
`define WNTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WNTM_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define WNTM_ASSERT(lbl, prop, msg)
`define WNTM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/wntm_pkg.sv @@
// Shared constants, codes and control structs of the nearest timestamp matcher.
// No dependencies.
package wntm_pkg;

	localparam int STORE_DEPTH    = 4096;
	localparam int BACK_WINDOW    = 10;
	localparam int FORWARD_WINDOW = 20;

	localparam int IDX_W   = $clog2(STORE_DEPTH);
	localparam int CNT_W   = IDX_W + 1;
	localparam int STAMP_W = 56;
	localparam int CFG_W   = 32;
	localparam int REQ_W   = 2;
	localparam int STS_W   = 3;

	localparam logic [CFG_W-1:0] GAP_RESET = 32'd20000;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR    = 2'd0,
		REQ_APPEND   = 2'd1,
		REQ_MATCH    = 2'd2,
		REQ_RESERVED = 2'd3
	} req_t;

	typedef enum logic [STS_W-1:0] {
		ST_MATCHED  = 3'd0,
		ST_NO_MATCH = 3'd1,
		ST_APPENDED = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef struct packed {
		logic    take;
		logic    clear;
		logic    append;
		logic    scan_init;
		logic    scan_run;
		logic    load_res;
		logic    res_match;
		status_t res_status;
	} wntm_cmd_t;

	typedef struct packed {
		logic full;
		logic scan_idle;
	} wntm_sts_t;

endpackage

@@ rtl/wntm_stream_if.sv @@
// Request and response channel interfaces (valid/ready) of the matcher.
// Depends on wntm_pkg.
interface wntm_req_if import wntm_pkg::*;;
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [STAMP_W-1:0] stamp;

	modport source (output valid, req_type, stamp, input ready);
	modport sink (input valid, req_type, stamp, output ready);
endinterface

interface wntm_rsp_if import wntm_pkg::*;;
	logic               valid;
	logic               ready;
	logic [STS_W-1:0]   status;
	logic [IDX_W-1:0]   match_index;
	logic [STAMP_W-1:0] match_stamp;
	logic [STAMP_W-1:0] gap;

	modport source (output valid, status, match_index, match_stamp, gap, input ready);
	modport sink (input valid, status, match_index, match_stamp, gap, output ready);
endinterface

@@ rtl/wntm_ctrl.sv @@
// Controller FSM: request decode, scan sequencing and result register handshake.
// Depends on wntm_pkg.
module wntm_ctrl import wntm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [REQ_W-1:0] in_req_type,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output wntm_cmd_t        cmd,
	input  wntm_sts_t        sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t  state_q;
	logic    out_valid_q;
	logic    res_match_q;
	status_t res_status_q;
	logic    accept;
	logic    load;
	req_t    req;

	assign req      = req_t'(in_req_type);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.take       = accept;
		cmd.clear      = accept && (req == REQ_CLEAR);
		cmd.append     = accept && (req == REQ_APPEND);
		cmd.scan_init  = accept && (req == REQ_MATCH);
		cmd.scan_run   = (state_q == S_SCAN);
		cmd.load_res   = load;
		cmd.res_match  = res_match_q;
		cmd.res_status = res_status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			res_match_q  <= 1'b0;
			res_status_q <= ST_NO_MATCH;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_match_q <= 1'b0;
						state_q     <= S_RESP;
						case (req)
							REQ_CLEAR:  res_status_q <= ST_CLEARED;
							REQ_APPEND: res_status_q <= sts.full ? ST_FULL : ST_APPENDED;
							REQ_MATCH: begin
								res_match_q <= 1'b1;
								state_q     <= S_SCAN;
							end
							default:    res_status_q <= ST_NO_MATCH;
						endcase
					end
				end
				S_SCAN: begin
					if (sts.scan_idle) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/wntm_dpath.sv @@
// Datapath: stamp store, fill count, search index, window scan pipeline,
// best-entry tracking and result registers. Depends on wntm_pkg and the assert header.
`include "windowed_nearest_timestamp_match_assert.svh"
module wntm_dpath import wntm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wntm_cmd_t          cmd,
	output wntm_sts_t          sts,
	input  logic [STAMP_W-1:0] in_stamp,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	output logic [STS_W-1:0]   res_status,
	output logic [IDX_W-1:0]   res_index,
	output logic [STAMP_W-1:0] res_stamp,
	output logic [STAMP_W-1:0] res_gap
);

	logic [STAMP_W-1:0] mem_q [STORE_DEPTH];

	logic [CFG_W-1:0]   max_gap_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   si_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   end_q;
	logic [STAMP_W-1:0] prim_q;

	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [STAMP_W-1:0] rd_s1;
	logic               v_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [STAMP_W-1:0] stamp_s2;
	logic [STAMP_W-1:0] d_s2;

	logic               any_q;
	logic [STAMP_W-1:0] best_gap_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;

	logic [STS_W-1:0]   o_status_q;
	logic [IDX_W-1:0]   o_index_q;
	logic [STAMP_W-1:0] o_stamp_q;
	logic [STAMP_W-1:0] o_gap_q;

	logic               full;
	logic               issue;
	logic               matched;
	logic [CNT_W:0]     fwd_lim;
	logic [CNT_W-1:0]   win_start;
	logic [CNT_W-1:0]   win_end;

	assign full    = (count_q == CNT_W'(STORE_DEPTH));
	assign issue   = cmd.scan_run && (ptr_q < end_q);
	assign matched = any_q && (best_gap_q <= {{(STAMP_W-CFG_W){1'b0}}, max_gap_q});

	assign fwd_lim   = (CNT_W+1)'(si_q) + (CNT_W+1)'(FORWARD_WINDOW);
	assign win_end   = (fwd_lim > (CNT_W+1)'(count_q)) ? count_q : fwd_lim[CNT_W-1:0];
	assign win_start = (si_q > IDX_W'(BACK_WINDOW)) ?
		CNT_W'(si_q - IDX_W'(BACK_WINDOW)) : '0;

	assign sts.full      = full;
	assign sts.scan_idle = !(ptr_q < end_q) && !v_s1 && !v_s2;

	assign res_status = o_status_q;
	assign res_index  = o_index_q;
	assign res_stamp  = o_stamp_q;
	assign res_gap    = o_gap_q;

	// store and payload pipeline
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem_q[count_q[IDX_W-1:0]] <= in_stamp;
		end
		rd_s1    <= mem_q[ptr_q[IDX_W-1:0]];
		idx_s1   <= ptr_q[IDX_W-1:0];
		idx_s2   <= idx_s1;
		stamp_s2 <= rd_s1;
		d_s2     <= (prim_q >= rd_s1) ? prim_q - rd_s1 : rd_s1 - prim_q;
		if (cmd.take) begin
			prim_q <= in_stamp;
		end
		if (v_s2 && (!any_q || d_s2 < best_gap_q)) begin
			best_gap_q   <= d_s2;
			best_idx_q   <= idx_s2;
			best_stamp_q <= stamp_s2;
		end
		if (cmd.load_res) begin
			if (cmd.res_match) begin
				o_status_q <= matched ? ST_MATCHED : ST_NO_MATCH;
				o_index_q  <= matched ? best_idx_q : '0;
				o_stamp_q  <= matched ? best_stamp_q : '0;
				o_gap_q    <= any_q ? best_gap_q : '0;
			end else begin
				o_status_q <= cmd.res_status;
				o_index_q  <= '0;
				o_stamp_q  <= '0;
				o_gap_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= GAP_RESET;
			count_q   <= '0;
			si_q      <= '0;
			ptr_q     <= '0;
			end_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			any_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_gap_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				count_q <= '0;
				si_q    <= '0;
			end else if (cmd.append && !full) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.load_res && cmd.res_match && matched) begin
				si_q <= best_idx_q;
			end
			if (cmd.scan_init) begin
				ptr_q <= win_start;
				end_q <= win_end;
				v_s1  <= 1'b0;
				v_s2  <= 1'b0;
				any_q <= 1'b0;
			end else begin
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
				v_s1 <= issue;
				v_s2 <= v_s1;
				if (v_s2) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	`WNTM_ASSERT(a_count_bound, count_q <= CNT_W'(STORE_DEPTH), "fill count exceeds store depth")
	`WNTM_ASSERT(a_si_in_store, (count_q == '0 && si_q == '0) || (CNT_W'(si_q) < count_q),
		"search index outside filled store")
	`WNTM_ASSERT_NEVER(a_read_unfilled, issue && !(ptr_q < count_q), "scan reads unfilled entry")
	`WNTM_ASSERT(a_best_from_scan, $rose(any_q) |-> $past(v_s2), "best entry set without a scanned beat")

endmodule

@@ rtl/windowed_nearest_timestamp_match.sv @@
// Nearest timestamp matcher. A request beat (clear, append or match) yields one response beat.
// Clear and append skip the scan. A match scans its window of the stamp store, at most
// BACK_WINDOW + FORWARD_WINDOW (30) entries, one per cycle through the store's single read port,
// through the scan pipeline, then loads the result register; one request is worked on at a time,
// and a new request is taken while the previous response still waits in the output register.
// The store needs no clearing pass after reset: a fill count marks valid entries.
// Depends on wntm_pkg, wntm_stream_if, wntm_ctrl and wntm_dpath.
module windowed_nearest_timestamp_match import wntm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	wntm_req_if.sink         req,
	wntm_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	wntm_cmd_t cmd;
	wntm_sts_t sts;

	wntm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	wntm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_stamp   (req.stamp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res_status (rsp.status),
		.res_index  (rsp.match_index),
		.res_stamp  (rsp.match_stamp),
		.res_gap    (rsp.gap)
	);

endmodule

@@ bench/timestamp_match_checker.sv @@
// Checker for the nearest timestamp matcher: watches request, response and config traffic,
// predicts every response from its own copy of the stamp store and compares in order.
// Depends on wntm_pkg and wntm_stream_if.
`timescale 1ns / 1ps
module timestamp_match_checker import wntm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	wntm_req_if              req,
	wntm_rsp_if              rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               pending
);

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   index;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] gap;
	} align_result_t;

	logic [STAMP_W-1:0] stamp_store [STORE_DEPTH];
	int unsigned        fill_count;
	int unsigned        search_pos;
	logic [CFG_W-1:0]   gap_limit;
	align_result_t      result_q [$];
	int                 fail_tally = 0;

	function automatic align_result_t align_request(input logic [REQ_W-1:0] kind,
			input logic [STAMP_W-1:0] primary);
		align_result_t      r;
		int unsigned        lo;
		int unsigned        hi;
		int unsigned        k;
		int unsigned        best;
		logic [STAMP_W-1:0] d;
		logic [STAMP_W-1:0] best_gap;
		bit                 found;
		r        = '0;
		r.status = ST_NO_MATCH;
		best     = 0;
		best_gap = '0;
		found    = 1'b0;
		case (kind)
			REQ_CLEAR: begin
				fill_count = 0;
				search_pos = 0;
				r.status   = ST_CLEARED;
			end
			REQ_APPEND: begin
				if (fill_count >= STORE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					stamp_store[fill_count] = primary;
					fill_count++;
					r.status = ST_APPENDED;
				end
			end
			REQ_MATCH: begin
				lo = (search_pos > BACK_WINDOW) ? search_pos - BACK_WINDOW : 0;
				hi = search_pos + FORWARD_WINDOW;
				if (hi > fill_count)
					hi = fill_count;
				for (k = lo; k < hi; k++) begin
					d = (primary >= stamp_store[k]) ? primary - stamp_store[k]
					                                : stamp_store[k] - primary;
					if (!found || d < best_gap) begin
						found    = 1'b1;
						best_gap = d;
						best     = k;
					end
				end
				if (found && best_gap <= {{(STAMP_W-CFG_W){1'b0}}, gap_limit}) begin
					search_pos = best;
					r.status   = ST_MATCHED;
					r.index    = best[IDX_W-1:0];
					r.stamp    = stamp_store[best];
				end
				r.gap = best_gap;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		align_result_t want;
		if (!arst_n) begin
			fill_count = 0;
			search_pos = 0;
			gap_limit  = GAP_RESET;
			result_q.delete();
		end else begin
			if (cfg_we)
				gap_limit = cfg_wdata;
			if (req.valid && req.ready)
				result_q.insert(result_q.size(), align_request(req.req_type, req.stamp));
			if (rsp.valid && rsp.ready) begin
				if (result_q.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("%0t: unexpected beat: sts %0d idx %0d stamp %h gap %h",
							$realtime, rsp.status, rsp.match_index, rsp.match_stamp,
							rsp.gap);
				end else begin
					want = result_q.pop_front();
					if (rsp.status !== want.status || rsp.match_index !== want.index ||
							rsp.match_stamp !== want.stamp || rsp.gap !== want.gap) begin
						fail_tally++;
						if (fail_tally <= 10)
							$display("%0t: exp %0d %0d %h %h, got %0d %0d %h %h",
								$realtime, want.status, want.index, want.stamp, want.gap,
								rsp.status, rsp.match_index, rsp.match_stamp, rsp.gap);
					end
				end
			end
		end
		mismatches <= fail_tally;
		pending    <= result_q.size();
	end

endmodule

@@ bench/testbench.sv @@
// Top of the matcher bench: clock, reset, request and config stimulus, response stalls,
// watchdog and verdict. Depends on wntm_pkg, wntm_stream_if, the matcher and the checker.
`timescale 1ns / 1ps
module testbench;
	import wntm_pkg::*;

	localparam int                 ITEM_TARGET = 1550;
	localparam int                 QUIET_LIMIT = 4000;
	localparam int                 HOLD_CYCLES = 400;
	localparam logic [STAMP_W-1:0] STAMP_MAX   = '1;
	localparam logic [CFG_W-1:0]   LIMIT_MAX   = '1;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_wdata;
	int                 mismatches;
	int                 pending;
	int                 sent = 0;
	int                 burst_left = 0;
	int                 hold_cycles = 0;
	int                 aim = 0;
	int                 quiet;
	logic [CFG_W-1:0]   limit_now = GAP_RESET;
	logic [STAMP_W-1:0] shadow_q [$];

	wntm_req_if req_ch ();
	wntm_rsp_if rsp_ch ();

	windowed_nearest_timestamp_match u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	timestamp_match_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [STAMP_W-1:0] rand_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[STAMP_W-1:0] >> $urandom_range(0, 40);
	endfunction

	function automatic logic [STAMP_W-1:0] stamp_near(input logic [STAMP_W-1:0] s,
			input logic [63:0] spread);
		logic [63:0] off;
		off = {$urandom, $urandom} % (spread + 64'd1);
		if ($urandom_range(0, 1))
			return ({8'b0, s} > {8'b0, STAMP_MAX} - off) ? STAMP_MAX : s + off[STAMP_W-1:0];
		return ({8'b0, s} < off) ? '0 : s - off[STAMP_W-1:0];
	endfunction

	task automatic send_beat(input req_t kind, input logic [STAMP_W-1:0] value);
		int idle;
		if (burst_left == 0) begin
			idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 16);
			if (idle > 0) begin
				req_ch.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.stamp    <= value;
		do @(posedge clk); while (!req_ch.ready);
		case (kind)
			REQ_CLEAR: begin
				shadow_q.delete();
				aim = 0;
			end
			REQ_APPEND: begin
				if (shadow_q.size() < STORE_DEPTH)
					shadow_q.insert(shadow_q.size(), value);
			end
			default: ;
		endcase
		if (kind != REQ_RESERVED)
			sent++;
	endtask

	// drop valid and wait until every response is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		limit_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// run of mostly ascending appends, then matches steered around the store, with some stray beats
	task automatic stamp_run();
		int                 n_app;
		int                 n_match;
		int                 k;
		logic [63:0]        step_scale;
		logic [63:0]        spread;
		logic [63:0]        nxt;
		logic [STAMP_W-1:0] s;
		if (shadow_q.size() > 3000 || $urandom_range(0, 3) != 0)
			send_beat(REQ_CLEAR, rand_stamp());
		s = ($urandom_range(0, 5) == 0) ? STAMP_MAX - STAMP_W'($urandom_range(0, 200000))
		                                : rand_stamp();
		case ($urandom_range(0, 2))
			0:       step_scale = 64'd2000;
			1:       step_scale = 64'd40000;
			default: step_scale = 64'd1 << $urandom_range(20, 40);
		endcase
		n_app = $urandom_range(1, 40);
		for (k = 0; k < n_app; k++) begin
			nxt = {8'b0, s} + ({$urandom, $urandom} % step_scale);
			s   = nxt[STAMP_W-1:0];
			if ($urandom_range(0, 15) == 0)
				s = rand_stamp();
			send_beat(REQ_APPEND, s);
		end
		n_match = $urandom_range(1, 40);
		for (k = 0; k < n_match; k++) begin
			case ($urandom_range(0, 2))
				0:       spread = {32'b0, limit_now} + {34'b0, limit_now[CFG_W-1:2]};
				1:       spread = step_scale;
				default: spread = 64'd50;
			endcase
			if ($urandom_range(0, 5) == 0) begin
				nxt = {8'b0, s} + ({$urandom, $urandom} % step_scale);
				s   = nxt[STAMP_W-1:0];
				send_beat(REQ_APPEND, s);
			end else if ($urandom_range(0, 19) == 0) begin
				send_beat(req_t'($urandom_range(0, 3)), rand_stamp());
			end else if (shadow_q.size() == 0) begin
				send_beat(REQ_MATCH, rand_stamp());
			end else begin
				aim = aim + int'($urandom_range(0, 12)) - 3;
				if (aim < 0)
					aim = 0;
				if (aim >= shadow_q.size())
					aim = shadow_q.size() - 1;
				send_beat(REQ_MATCH, stamp_near(shadow_q[aim], spread));
			end
		end
	endtask

	task automatic noise_run();
		int n;
		int k;
		n = $urandom_range(1, 10);
		for (k = 0; k < n; k++)
			send_beat(req_t'($urandom_range(0, 3)), ($urandom_range(0, 1) && shadow_q.size() > 0)
				? stamp_near(shadow_q[$urandom_range(0, shadow_q.size() - 1)], 64'd100000)
				: rand_stamp());
	endtask

	// response side: ready pattern changes mode every window; a hold request wins
	initial begin
		int mode;
		int window;
		mode         = 0;
		window       = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (window == 0) begin
				mode   = $urandom_range(0, 3);
				window = $urandom_range(20, 200);
			end
			window--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0:       rsp_ch.ready <= 1'b1;
					1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
					2:       rsp_ch.ready <= ($urandom_range(0, 9) < 2);
					default: rsp_ch.ready <= window[2];
				endcase
			end
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int runs;
		bit held;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_CLEAR;
		req_ch.stamp    = '0;
		held            = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, reserved code, extremes, ties, limit boundary
		send_beat(REQ_MATCH, 56'd5);
		send_beat(REQ_RESERVED, STAMP_MAX);
		send_beat(REQ_RESERVED, '0);
		send_beat(REQ_APPEND, '0);
		send_beat(REQ_MATCH, STAMP_MAX);
		send_beat(REQ_APPEND, STAMP_MAX);
		send_beat(REQ_MATCH, STAMP_MAX);
		send_beat(REQ_APPEND, 56'd100);
		send_beat(REQ_MATCH, 56'd50);
		send_beat(REQ_MATCH, 56'd20050);
		send_beat(REQ_MATCH, 56'd20101);
		send_beat(REQ_MATCH, 56'd20100);
		send_beat(REQ_CLEAR, STAMP_MAX);
		send_beat(REQ_MATCH, '0);
		write_limit('0);
		send_beat(REQ_APPEND, 56'd7);
		send_beat(REQ_MATCH, 56'd7);
		send_beat(REQ_MATCH, 56'd8);
		write_limit(LIMIT_MAX);
		send_beat(REQ_MATCH, 56'd7 + {24'b0, LIMIT_MAX});
		send_beat(REQ_MATCH, 56'd8 + {24'b0, LIMIT_MAX});
		send_beat(REQ_CLEAR, '0);

		// random part
		write_limit(GAP_RESET);
		runs = 0;
		while (sent < ITEM_TARGET) begin
			if (runs % 6 == 5) begin
				case ($urandom_range(0, 4))
					0:       write_limit('0);
					1:       write_limit(LIMIT_MAX);
					2:       write_limit(GAP_RESET);
					3:       write_limit($urandom_range(0, 100000));
					default: write_limit($urandom);
				endcase
			end
			if (!held && sent > ITEM_TARGET / 2) begin
				hold_cycles = HOLD_CYCLES;
				held        = 1'b1;
			end
			if ($urandom_range(0, 9) < 8)
				stamp_run();
			else
				noise_run();
			runs++;
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ windowed_nearest_timestamp_match.f @@
+incdir+rtl
rtl/wntm_pkg.sv
rtl/wntm_stream_if.sv
rtl/wntm_ctrl.sv
rtl/wntm_dpath.sv
rtl/windowed_nearest_timestamp_match.sv
bench/timestamp_match_checker.sv
bench/testbench.sv
